@@ hw/rtl/dpgc_pkg.sv @@
package dpgc_pkg;

   // Palette layout
   localparam int NUM_STOPS = 7;
   localparam int CHAN_W    = 8;
   localparam int NUM_CHAN  = 3;
   localparam int COLOUR_W  = NUM_CHAN * CHAN_W;
   localparam int STOP_W    = 3;

   // Item field widths
   localparam int COORD_W   = 12;
   localparam int DEPTH_W   = 12;
   localparam int LINE_W    = 16;
   localparam int OFFSET_W  = 28;

   // Configuration port
   localparam int CSR_IDX_W = 4;

   // Parameter defaults
   localparam int ITER_LIMIT_DEF      = 256;
   localparam int BYTES_PER_PIXEL_DEF = 4;

   typedef logic [COLOUR_W-1:0] colour_type;
   typedef colour_type [NUM_STOPS-1:0] palette_type;
   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   // Register map
   localparam csr_index_type REG_PALETTE_LAST = csr_index_type'(NUM_STOPS - 1);
   localparam csr_index_type REG_LINE_BYTES   = csr_index_type'(NUM_STOPS);

endpackage

@@ hw/rtl/dpgc_band_sel.sv @@
module dpgc_band_sel
   import dpgc_pkg::*;
#(
   parameter  int ITER_LIMIT = ITER_LIMIT_DEF,
   localparam int SEG        = ITER_LIMIT / NUM_STOPS,
   localparam int SEG_W      = $clog2(SEG + 1)
) (
   input  logic               clock,
   input  logic               advance,
   input  logic [DEPTH_W-1:0] depth,
   input  palette_type        palette,
   output colour_type         stop_a,
   output colour_type         stop_b,
   output logic [SEG_W-1:0]   blend_t
);

   localparam int TOP_BORDER = (NUM_STOPS - 1) * SEG;

   logic [STOP_W-1:0]  band;
   logic [DEPTH_W-1:0] base;
   logic [DEPTH_W-1:0] t_full;
   colour_type         stop_a_in, stop_a_ff;
   colour_type         stop_b_in, stop_b_ff;
   logic [SEG_W-1:0]   blend_t_in, blend_t_ff;

   // Band search: compare against every lower border in parallel, keep the highest hit.
   always_comb begin
      band = STOP_W'(1);
      base = '0;
      for (int j = 2; j < NUM_STOPS; j++) begin
         if (depth > DEPTH_W'((j - 1) * SEG)) begin
            band = STOP_W'(j);
            base = DEPTH_W'((j - 1) * SEG);
         end
      end
      t_full = depth - base;

      // Black and the top band become a blend of equal stops at full weight.
      if (depth == '0) begin
         stop_a_in  = '0;
         stop_b_in  = '0;
         blend_t_in = SEG_W'(SEG);
      end else if (depth > DEPTH_W'(TOP_BORDER)) begin
         stop_a_in  = palette[NUM_STOPS-1];
         stop_b_in  = palette[NUM_STOPS-1];
         blend_t_in = SEG_W'(SEG);
      end else begin
         stop_a_in  = palette[band - STOP_W'(1)];
         stop_b_in  = palette[band];
         blend_t_in = t_full[SEG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         stop_a_ff  <= stop_a_in;
         stop_b_ff  <= stop_b_in;
         blend_t_ff <= blend_t_in;
      end
   end

   assign stop_a  = stop_a_ff;
   assign stop_b  = stop_b_ff;
   assign blend_t = blend_t_ff;

endmodule

@@ hw/rtl/dpgc_blend.sv @@
module dpgc_blend
   import dpgc_pkg::*;
#(
   parameter  int ITER_LIMIT = ITER_LIMIT_DEF,
   localparam int SEG        = ITER_LIMIT / NUM_STOPS,
   localparam int SEG_W      = $clog2(SEG + 1),
   localparam int NUM_W      = CHAN_W + SEG_W
) (
   input  logic                            clock,
   input  logic                            advance,
   input  colour_type                      stop_a,
   input  colour_type                      stop_b,
   input  logic [SEG_W-1:0]                blend_t,
   output logic [NUM_CHAN-1:0][NUM_W-1:0]  numer
);

   logic [SEG_W-1:0]               t_inv;
   logic [NUM_CHAN-1:0][NUM_W-1:0] numer_in, numer_ff;

   assign t_inv = SEG_W'(SEG) - blend_t;

   // Weighted sum per channel, bounded by 255 * SEG.
   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         numer_in[c] = NUM_W'(stop_a[c*CHAN_W +: CHAN_W]) * NUM_W'(t_inv)
                     + NUM_W'(stop_b[c*CHAN_W +: CHAN_W]) * NUM_W'(blend_t);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         numer_ff <= numer_in;
      end
   end

   assign numer = numer_ff;

endmodule

@@ hw/rtl/dpgc_divide.sv @@
module dpgc_divide
   import dpgc_pkg::*;
#(
   parameter  int ITER_LIMIT = ITER_LIMIT_DEF,
   localparam int SEG        = ITER_LIMIT / NUM_STOPS,
   localparam int SEG_W      = $clog2(SEG + 1),
   localparam int NUM_W      = CHAN_W + SEG_W
) (
   input  logic                            clock,
   input  logic                            advance,
   input  logic [NUM_CHAN-1:0][NUM_W-1:0]  numer,
   output colour_type                      quotient
);

   // Truncated reciprocal: the estimate is exact or one low, fixed by one compare.
   localparam int RECIP   = (2 ** NUM_W) / SEG;
   localparam int PROD_W  = 2 * NUM_W + 1;

   logic [NUM_CHAN-1:0][PROD_W-1:0] prod;
   logic [NUM_CHAN-1:0][CHAN_W-1:0] q_est_ff;
   logic [NUM_CHAN-1:0][NUM_W-1:0]  numer_ff;
   logic [NUM_CHAN-1:0][NUM_W-1:0]  rem;
   colour_type                      quotient_in, quotient_ff;

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         prod[c] = PROD_W'(numer[c]) * PROD_W'(RECIP);
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CHAN; c++) begin
         rem[c] = numer_ff[c] - NUM_W'(q_est_ff[c]) * NUM_W'(SEG);
         if (rem[c] >= NUM_W'(SEG)) begin
            quotient_in[c*CHAN_W +: CHAN_W] = q_est_ff[c] + CHAN_W'(1);
         end else begin
            quotient_in[c*CHAN_W +: CHAN_W] = q_est_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < NUM_CHAN; c++) begin
            q_est_ff[c] <= prod[c][NUM_W +: CHAN_W];
         end
         numer_ff    <= numer;
         quotient_ff <= quotient_in;
      end
   end

   assign quotient = quotient_ff;

endmodule

@@ hw/rtl/depth_palette_gradient_colour.sv @@
// Channel   Direction  Handshake              Payload
// req_      in         req_valid/req_ready    pixel_x, pixel_y, iter_depth
// rsp_      out        rsp_valid/rsp_ready    pixel_colour, byte_offset
// csr_      in         csr_valid/csr_ready    csr_index, csr_data
//
// Four-stage pipeline: one item per cycle while rsp_ready does not hold the
// output; rsp_valid rises once the item reaches the output register.
// The stages are band select, channel weighting, reciprocal multiply, and the
// quotient correction that feeds the output register.
// Synchronous active-high reset clears the valid chain and the configuration registers.
// A stall on rsp_ready freezes every stage at once; req_ready follows it.
module depth_palette_gradient_colour
   import dpgc_pkg::*;
#(
   parameter int ITER_LIMIT      = ITER_LIMIT_DEF,
   parameter int BYTES_PER_PIXEL = BYTES_PER_PIXEL_DEF
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_ready,
   input  logic [COORD_W-1:0]  req_pixel_x,
   input  logic [COORD_W-1:0]  req_pixel_y,
   input  logic [DEPTH_W-1:0]  req_iter_depth,

   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [COLOUR_W-1:0] rsp_pixel_colour,
   output logic [OFFSET_W-1:0] rsp_byte_offset,

   input  logic                csr_valid,
   output logic                csr_ready,
   input  csr_index_type       csr_index,
   input  logic [COLOUR_W-1:0] csr_data
);

   localparam int SEG        = ITER_LIMIT / NUM_STOPS;
   localparam int SEG_W      = $clog2(SEG + 1);
   localparam int NUM_W      = CHAN_W + SEG_W;
   localparam int NUM_STAGES = 4;

   palette_type                    palette_ff;
   logic [LINE_W-1:0]              line_bytes_ff;
   logic [NUM_STAGES-1:0]          valid_ff;
   logic                           advance;

   colour_type                     stop_a;
   colour_type                     stop_b;
   logic [SEG_W-1:0]               blend_t;
   logic [NUM_CHAN-1:0][NUM_W-1:0] numer;
   colour_type                     quotient;

   logic [OFFSET_W-1:0]            yline_in, yline_ff;
   logic [COORD_W-1:0]             x_ff;
   logic [OFFSET_W-1:0]            offset_in;
   logic [OFFSET_W-1:0]            offset_s2_ff, offset_s3_ff, offset_s4_ff;

   // The whole pipe moves together unless the output register is full and held.
   assign advance   = !valid_ff[NUM_STAGES-1] || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   // Register writes; indexes past the map are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         palette_ff    <= '0;
         line_bytes_ff <= '0;
      end else if (csr_valid) begin
         if (csr_index <= REG_PALETTE_LAST) begin
            palette_ff[csr_index[STOP_W-1:0]] <= csr_data;
         end else if (csr_index == REG_LINE_BYTES) begin
            line_bytes_ff <= csr_data[LINE_W-1:0];
         end
      end
   end

   // Valid bits shift alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[NUM_STAGES-2:0], req_valid};
      end
   end

   // Stage 1: band lookup and stop selection.
   dpgc_band_sel #(
      .ITER_LIMIT (ITER_LIMIT)
   ) u_band_sel (
      .clock   (clock),
      .advance (advance),
      .depth   (req_iter_depth),
      .palette (palette_ff),
      .stop_a  (stop_a),
      .stop_b  (stop_b),
      .blend_t (blend_t)
   );

   // Stage 2: per-channel weighted sum.
   dpgc_blend #(
      .ITER_LIMIT (ITER_LIMIT)
   ) u_blend (
      .clock   (clock),
      .advance (advance),
      .stop_a  (stop_a),
      .stop_b  (stop_b),
      .blend_t (blend_t),
      .numer   (numer)
   );

   // Stages 3 and 4: divide by the segment length.
   dpgc_divide #(
      .ITER_LIMIT (ITER_LIMIT)
   ) u_divide (
      .clock    (clock),
      .advance  (advance),
      .numer    (numer),
      .quotient (quotient)
   );

   // Offset path: row product in stage 1, column term added in stage 2,
   // then delay to line up with the colour.
   assign yline_in  = OFFSET_W'(req_pixel_y) * OFFSET_W'(line_bytes_ff);
   assign offset_in = yline_ff + OFFSET_W'(x_ff) * OFFSET_W'(BYTES_PER_PIXEL);

   always_ff @(posedge clock) begin
      if (advance) begin
         yline_ff     <= yline_in;
         x_ff         <= req_pixel_x;
         offset_s2_ff <= offset_in;
         offset_s3_ff <= offset_s2_ff;
         offset_s4_ff <= offset_s3_ff;
      end
   end

   assign rsp_valid        = valid_ff[NUM_STAGES-1];
   assign rsp_pixel_colour = quotient;
   assign rsp_byte_offset  = offset_s4_ff;

endmodule
